// ===== design/bootp_reply_option_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// bootp reply option parser assertion macros
// shared concurrent assertion forms for the parser core
// ----------------------------------------------------------------------------
`ifndef BOOTP_REPLY_OPTION_PARSER_CORE_MACROS_SVH
`define BOOTP_REPLY_OPTION_PARSER_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define BROP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brop check failed");

// condition implies consequence in the following cycle
`define BROP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brop check failed");

`endif

// ===== design/brop_pkg.sv =====
// ----------------------------------------------------------------------------
// brop_pkg
// constants, codes and shared types of the bootp reply option parser
// ----------------------------------------------------------------------------
package brop_pkg;

   // layout of the reply
   localparam int VENDOR_AREA_BYTES = 64;
   localparam int FIXED_BYTES       = 236;
   localparam int TOTAL_BYTES       = FIXED_BYTES + VENDOR_AREA_BYTES;

   // byte position counter, saturating
   localparam int POS_W = 10;
   localparam logic [POS_W-1:0] POS_OP         = POS_W'(0);
   localparam logic [POS_W-1:0] POS_YIADDR_LO  = POS_W'(16);
   localparam logic [POS_W-1:0] POS_YIADDR_HI  = POS_W'(19);
   localparam logic [POS_W-1:0] POS_COOKIE_LO  = POS_W'(FIXED_BYTES);
   localparam logic [POS_W-1:0] POS_COOKIE_HI  = POS_W'(FIXED_BYTES + 3);
   localparam logic [POS_W-1:0] POS_OPTIONS    = POS_W'(FIXED_BYTES + 4);
   localparam logic [POS_W-1:0] POS_TOTAL      = POS_W'(TOTAL_BYTES);
   localparam logic [POS_W-1:0] POS_LAST       = POS_W'(TOTAL_BYTES - 1);
   localparam logic [15:0]      LENGTH_EXPECTED = 16'(TOTAL_BYTES);

   localparam logic [7:0]  OP_REPLY     = 8'd2;
   localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

   // option codes
   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_SUBNET   = 8'd1;
   localparam logic [7:0] OPT_GATEWAY  = 8'd3;
   localparam logic [7:0] OPT_DNS      = 8'd6;
   localparam logic [7:0] OPT_HOSTNAME = 8'd12;
   localparam logic [7:0] OPT_END      = 8'd255;

   // result kinds
   localparam logic [2:0] KIND_ADDRESS    = 3'd0;
   localparam logic [2:0] KIND_MASK       = 3'd1;
   localparam logic [2:0] KIND_BROADCAST  = 3'd2;
   localparam logic [2:0] KIND_HOSTNAME   = 3'd3;
   localparam logic [2:0] KIND_NAMESERVER = 3'd4;
   localparam logic [2:0] KIND_GATEWAY    = 3'd5;
   localparam logic [2:0] KIND_ACCEPTED   = 3'd6;
   localparam logic [2:0] KIND_REJECTED   = 3'd7;

   // configuration port
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        CSR_IFACE_WORD  = 1'b0;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last_result;
   } result_type;

   // results caused by one byte, handed to the output queue
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] item;
   } batch_type;

endpackage

// ===== design/brop_parser.sv =====
// ----------------------------------------------------------------------------
// brop_parser
// per-packet parse state and the single-pass byte decode
// ----------------------------------------------------------------------------
module brop_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic [15:0]            packet_length,
   input  logic                   end_of_packet,
   input  logic [31:0]            interface_address,
   output brop_pkg::batch_type    batch
);

   typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_DATA, PH_DONE} phase_type;

   logic [brop_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       reject_ff, reject_in;
   logic [31:0]                learned_ff, learned_in;
   logic [31:0]                acc_ff, acc_in;
   phase_type                  phase_ff, phase_in;
   logic [7:0]                 code_ff, code_in;
   logic [7:0]                 remain_ff, remain_in;
   logic [2:0]                 fill_ff, fill_in;

   logic [31:0] cur_addr;
   logic [31:0] shifted;
   logic        last_vendor;
   logic        ok;
   logic [1:0]  main_cnt;
   brop_pkg::result_type m0, m1, status;

   assign cur_addr    = (interface_address != 32'd0) ? interface_address : learned_ff;
   assign shifted     = {acc_ff[23:0], data_byte};
   assign last_vendor = (pos_ff == brop_pkg::POS_LAST);

   // byte decode
   always_comb begin
      pos_in     = pos_ff;
      reject_in  = reject_ff;
      learned_in = learned_ff;
      acc_in     = acc_ff;
      phase_in   = phase_ff;
      code_in    = code_ff;
      remain_in  = remain_ff;
      fill_in    = fill_ff;
      main_cnt   = 2'd0;
      m0         = '0;
      m1         = '0;
      status     = '0;
      ok         = 1'b0;
      batch      = '0;

      if (packet_length != brop_pkg::LENGTH_EXPECTED || pos_ff >= brop_pkg::POS_TOTAL) begin
         reject_in = 1'b1;
      end

      if (!reject_in) begin
         if (pos_ff == brop_pkg::POS_OP) begin
            if (data_byte != brop_pkg::OP_REPLY) begin
               reject_in = 1'b1;
            end
         end else if (pos_ff >= brop_pkg::POS_YIADDR_LO && pos_ff <= brop_pkg::POS_YIADDR_HI) begin
            acc_in = shifted;
            if (pos_ff == brop_pkg::POS_YIADDR_HI && cur_addr == 32'd0) begin
               learned_in = shifted;
               m0         = '{kind: brop_pkg::KIND_ADDRESS, value: shifted, last_result: 1'b0};
               main_cnt   = 2'd1;
            end
         end else if (pos_ff >= brop_pkg::POS_COOKIE_LO && pos_ff <= brop_pkg::POS_COOKIE_HI) begin
            acc_in = shifted;
            if (pos_ff == brop_pkg::POS_COOKIE_HI && shifted != brop_pkg::MAGIC_COOKIE) begin
               reject_in = 1'b1;
            end
         end else if (pos_ff >= brop_pkg::POS_OPTIONS) begin
            // option walk
            case (phase_ff)
               PH_CODE: begin
                  if (data_byte == brop_pkg::OPT_END || last_vendor) begin
                     phase_in = PH_DONE;
                  end else if (data_byte != brop_pkg::OPT_PAD) begin
                     code_in  = data_byte;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  remain_in = (code_ff == brop_pkg::OPT_SUBNET) ? 8'd4 : data_byte;
                  fill_in   = 3'd0;
                  acc_in    = 32'd0;
                  phase_in  = (remain_in == 8'd0) ? PH_CODE : PH_DATA;
                  if (last_vendor) begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DATA: begin
                  remain_in = remain_ff - 8'd1;
                  acc_in    = shifted;
                  fill_in   = (fill_ff != 3'd7) ? fill_ff + 3'd1 : fill_ff;
                  if (code_ff == brop_pkg::OPT_SUBNET && fill_in == 3'd4) begin
                     m0       = '{kind: brop_pkg::KIND_MASK, value: shifted, last_result: 1'b0};
                     m1       = '{kind: brop_pkg::KIND_BROADCAST, value: cur_addr | ~shifted,
                                  last_result: 1'b0};
                     main_cnt = 2'd2;
                  end else if (code_ff == brop_pkg::OPT_DNS && fill_in == 3'd4) begin
                     m0       = '{kind: brop_pkg::KIND_NAMESERVER, value: shifted,
                                  last_result: 1'b0};
                     main_cnt = 2'd1;
                     fill_in  = 3'd0;
                  end else if (code_ff == brop_pkg::OPT_GATEWAY && fill_in == 3'd4) begin
                     m0       = '{kind: brop_pkg::KIND_GATEWAY, value: shifted, last_result: 1'b0};
                     main_cnt = 2'd1;
                  end else if (code_ff == brop_pkg::OPT_HOSTNAME) begin
                     m0       = '{kind: brop_pkg::KIND_HOSTNAME, value: {24'd0, data_byte},
                                  last_result: 1'b0};
                     main_cnt = 2'd1;
                  end
                  if (remain_in == 8'd0) begin
                     phase_in = PH_CODE;
                  end
                  if (last_vendor) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end

      if (pos_ff != {brop_pkg::POS_W{1'b1}}) begin
         pos_in = pos_ff + brop_pkg::POS_W'(1);
      end

      // assemble the result batch
      batch.item[0] = m0;
      batch.item[1] = m1;
      batch.count   = main_cnt;
      if (end_of_packet) begin
         ok     = !reject_in && last_vendor;
         status = '{kind: ok ? brop_pkg::KIND_ACCEPTED : brop_pkg::KIND_REJECTED,
                    value: 32'd0, last_result: 1'b1};
         case (main_cnt)
            2'd0:    batch.item[0] = status;
            2'd1:    batch.item[1] = status;
            default: batch.item[2] = status;
         endcase
         batch.count = main_cnt + 2'd1;
         // per-packet state back to its start
         pos_in    = '0;
         reject_in = 1'b0;
         acc_in    = 32'd0;
         phase_in  = PH_CODE;
         code_in   = 8'd0;
         remain_in = 8'd0;
         fill_in   = 3'd0;
      end else begin
         case (main_cnt)
            2'd1:    batch.item[0].last_result = 1'b1;
            2'd2:    batch.item[1].last_result = 1'b1;
            default: batch.item[0].last_result = 1'b0;
         endcase
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         reject_ff  <= 1'b0;
         learned_ff <= 32'd0;
         acc_ff     <= 32'd0;
         phase_ff   <= PH_CODE;
         code_ff    <= 8'd0;
         remain_ff  <= 8'd0;
         fill_ff    <= 3'd0;
      end else if (step) begin
         pos_ff     <= pos_in;
         reject_ff  <= reject_in;
         learned_ff <= learned_in;
         acc_ff     <= acc_in;
         phase_ff   <= phase_in;
         code_ff    <= code_in;
         remain_ff  <= remain_in;
         fill_ff    <= fill_in;
      end
   end

endmodule

// ===== design/brop_out_queue.sv =====
// ----------------------------------------------------------------------------
// brop_out_queue
// holds the results of one byte and hands them out one per transfer
// ----------------------------------------------------------------------------
module brop_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  brop_pkg::batch_type batch,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_kind,
   output logic [31:0]         rsp_value,
   output logic                rsp_last_result
);

   brop_pkg::result_type item_ff [brop_pkg::MAX_RESULTS];
   logic [1:0] cnt_ff;
   logic [1:0] idx_ff;
   logic       take;
   logic       last_take;

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign take            = rsp_valid && !rsp_stall;
   assign last_take       = take && (idx_ff == cnt_ff - 2'd1);
   assign free            = (cnt_ff == 2'd0) || last_take;
   assign rsp_kind        = item_ff[idx_ff].kind;
   assign rsp_value       = item_ff[idx_ff].value;
   assign rsp_last_result = item_ff[idx_ff].last_result;

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < brop_pkg::MAX_RESULTS; i++) begin
            item_ff[i] <= batch.item[i];
         end
      end
   end

   // fill count and read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else if (push) begin
         cnt_ff <= batch.count;
         idx_ff <= 2'd0;
      end else if (last_take) begin
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

// ===== design/bootp_reply_option_parser_core.sv =====
// ----------------------------------------------------------------------------
// bootp_reply_option_parser_core
// Parses a BOOTP reply one payload byte per transfer and reports the learned
// address, subnet mask, broadcast, hostname bytes, name servers, gateway and a
// final accepted or rejected status. A byte is registered on input, decoded
// combinationally and its results (zero to three) land in an output queue that
// drains one result per cycle while rsp_stall is low. A byte that yields at most
// one result is taken every cycle while rsp_stall is low; a byte that yields
// several results holds the queue until they drain, and the input stalls until
// then. The input register and the queue register lie before the first result.
// ----------------------------------------------------------------------------
`include "bootp_reply_option_parser_core_macros.svh"

module bootp_reply_option_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   // byte input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic [15:0]                     req_packet_length,
   input  logic                            req_end_of_packet,
   // results
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_kind,
   output logic [31:0]                     rsp_value,
   output logic                            rsp_last_result,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [brop_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic        in_valid_ff;
   logic [7:0]  byte_ff;
   logic [15:0] length_ff;
   logic        eop_ff;
   logic [31:0] iface_ff;
   logic        accept;
   logic        step;
   logic        free;
   logic        cfg_wr;
   brop_pkg::batch_type batch;

   // register port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[brop_pkg::CSR_ADDR_W-1] == brop_pkg::CSR_IFACE_WORD);
   assign csr_prdata = (csr_paddr[brop_pkg::CSR_ADDR_W-1] == brop_pkg::CSR_IFACE_WORD) ?
                       iface_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_ff <= 32'd0;
      end else if (cfg_wr) begin
         iface_ff <= csr_pwdata;
      end
   end

   // input register handshake
   assign step      = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff   <= req_data_byte;
         length_ff <= req_packet_length;
         eop_ff    <= req_end_of_packet;
      end
   end

   brop_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .data_byte         (byte_ff),
      .packet_length     (length_ff),
      .end_of_packet     (eop_ff),
      .interface_address (iface_ff),
      .batch             (batch)
   );

   brop_out_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (step),
      .batch           (batch),
      .free            (free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_last_result (rsp_last_result)
   );

   // checks
   `BROP_ASSERT_SAME(a_stall_only_when_holding, clock, reset, req_stall, in_valid_ff)
   `BROP_ASSERT_NEXT(a_packet_end_gives_status, clock, reset, step && eop_ff, rsp_valid)
   `BROP_ASSERT_NEXT(a_iface_write_lands, clock, reset, cfg_wr, iface_ff == $past(csr_pwdata))

endmodule
